// ===== hdl/xrr_pkg.sv =====
`default_nettype none

package xrr_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CntW = $clog2(WordW);

  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 5;

  localparam logic [WordW-1:0] GenResetValue = 32'd1;

  localparam logic ReqDraw = 1'b0;
  localparam logic ReqReseed = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [WordW-1:0]   seed_value;
    logic signed [WordW-1:0] range_low;
    logic signed [WordW-1:0] range_high;
  } in_word_t;

  typedef struct packed {
    logic signed [WordW-1:0] rand_value;
    logic                    advanced;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_ADD
  } seq_state_t;

  function automatic logic [WordW-1:0] xorshift_next(input logic [WordW-1:0] x);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    a = x ^ (x << ShiftA);
    b = a ^ (a >> ShiftB);
    return b ^ (b << ShiftC);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/xorshift_range_random.sv =====
`default_nettype none

// channel   dir  ports                              word
// in        in   in_valid, in_ready, in_data        in_word_t
// out       out  out_valid, out_ready, out_data     out_word_t
//
// Reseed and empty-range words finish at acceptance: result valid in the next cycle.
// A draw runs one xorshift step, then the bit-serial remainder unit, then a
// state that sees it done, then an add into the free output register.
// in_ready is high only while the sequencer is idle and the output register is
// empty or draining. rst_n is synchronous; state resets to 1.
module xorshift_range_random
  import xrr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  seq_state_t       state_r, state_nxt;
  logic [WordW-1:0] gen_r, gen_nxt;
  logic [WordW-1:0] lo_r, lo_nxt;
  logic [WordW-1:0] span_r, span_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_r, out_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic out_free;
  logic in_acc;
  logic empty_range;

  xrr_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_free    = !out_valid_r || out_ready;
  assign in_ready    = (state_r == ST_IDLE) && out_free;
  assign in_acc      = in_valid && in_ready;
  assign empty_range = in_data.range_low >= in_data.range_high;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.req_type == ReqDraw && !empty_range) state_nxt = ST_STEP;
      end
      ST_STEP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (!out_valid_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    gen_nxt          = gen_r;
    lo_nxt           = lo_r;
    span_nxt         = span_r;
    out_nxt          = out_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    div_req.start    = 1'b0;
    div_req.dividend = xorshift_next(gen_r);
    div_req.divisor  = span_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          lo_nxt   = in_data.range_low;
          span_nxt = in_data.range_high - in_data.range_low;
          if (in_data.req_type == ReqReseed) begin
            if (in_data.seed_value != '0) gen_nxt = in_data.seed_value;
            out_nxt.rand_value = '0;
            out_nxt.advanced   = 1'b0;
            out_valid_nxt      = 1'b1;
          end else if (empty_range) begin
            out_nxt.rand_value = in_data.range_low;
            out_nxt.advanced   = 1'b0;
            out_valid_nxt      = 1'b1;
          end
        end
      end
      ST_STEP: begin
        gen_nxt       = xorshift_next(gen_r);
        div_req.start = 1'b1;
      end
      ST_ADD: begin
        if (!out_valid_r) begin
          out_nxt.rand_value = lo_r + div_rsp.remainder;
          out_nxt.advanced   = 1'b1;
          out_valid_nxt      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gen_r       <= GenResetValue;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r   <= lo_nxt;
    span_r <= span_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== hdl/xrr_divider.sv =====
`default_nettype none

// restoring remainder, one dividend bit per cycle
module xrr_divider
  import xrr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic [WordW-1:0] rem_r, rem_nxt;
  logic [WordW-1:0] dvd_r, dvd_nxt;
  logic [WordW-1:0] dvs_r, dvs_nxt;

  logic [WordW:0]   shifted;
  logic [WordW:0]   diff;
  logic [WordW-1:0] rem_step;

  always_comb begin
    shifted  = {rem_r, dvd_r[WordW-1]};
    diff     = shifted - {1'b0, dvs_r};
    rem_step = diff[WordW] ? shifted[WordW-1:0] : diff[WordW-1:0];
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      count_nxt = '0;
      rem_nxt   = '0;
      dvd_nxt   = req.dividend;
      dvs_nxt   = req.divisor;
    end else if (busy_r) begin
      rem_nxt   = rem_step;
      dvd_nxt   = {dvd_r[WordW-2:0], 1'b0};
      count_nxt = count_r + 1'b1;
      if (count_r == CntW'(WordW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import xrr_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned DrainCycles = 60;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  logic [WordW-1:0] gen_model_state;
  out_word_t pending_words[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned ready_hold = 0;
  bit idle_on = 1'b1;

  xorshift_range_random i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // xorshift32 step, shifts 13 / 17 / 5
  function automatic logic [WordW-1:0] xs32_step(input logic [WordW-1:0] x);
    logic [WordW-1:0] t;
    t = x ^ {x[18:0], 13'b0};
    t = t ^ {17'b0, t[31:17]};
    return t ^ {t[26:0], 5'b0};
  endfunction

  function automatic out_word_t predict_word(input in_word_t w);
    out_word_t r;
    logic [WordW-1:0] span;
    logic [WordW-1:0] rem;
    r = '0;
    if (w.req_type == ReqReseed) begin
      if (w.seed_value != '0) gen_model_state = w.seed_value;
    end else if ($signed(w.range_low) >= $signed(w.range_high)) begin
      r.rand_value = w.range_low;
    end else begin
      span = w.range_high - w.range_low;
      gen_model_state = xs32_step(gen_model_state);
      rem = gen_model_state % span;
      r.rand_value = w.range_low + rem;
      r.advanced = 1'b1;
    end
    return r;
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_on && out_ready && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: rand_value %0d advanced %0b",
               $signed(out_data.rand_value), out_data.advanced);
        err_count++;
      end else begin
        exp_w = pending_words[0];
        pending_words.delete(0);
        if (out_data.rand_value !== exp_w.rand_value) begin
          $error("rand_value: expected %0d, got %0d",
                 $signed(exp_w.rand_value), $signed(out_data.rand_value));
          err_count++;
        end
        if (out_data.advanced !== exp_w.advanced) begin
          $error("advanced: expected %0b, got %0b", exp_w.advanced, out_data.advanced);
          err_count++;
        end
      end
    end
  end

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    pending_words = {pending_words, predict_word(w)};
  endtask

  function automatic in_word_t make_draw(input int lo, input int hi);
    in_word_t w;
    w.req_type = ReqDraw;
    w.seed_value = $urandom;
    w.range_low = lo;
    w.range_high = hi;
    return w;
  endfunction

  function automatic in_word_t make_reseed(input logic [WordW-1:0] seed);
    in_word_t w;
    w.req_type = ReqReseed;
    w.seed_value = seed;
    w.range_low = $urandom;
    w.range_high = $urandom;
    return w;
  endfunction

  task automatic test_reset_draw();
    send_word(make_draw(0, 100));
    send_word(make_draw(0, 32'sh7fff_ffff));
    send_word(make_draw(-5, 5));
  endtask

  task automatic test_empty_ranges();
    send_word(make_draw(5, 5));
    send_word(make_draw(10, -10));
    send_word(make_draw(32'sh7fff_ffff, 32'sh8000_0000));
    send_word(make_draw(32'sh8000_0000, 32'sh8000_0000));
    send_word(make_draw(32'sh7fff_ffff, 32'sh7fff_ffff));
  endtask

  task automatic test_wide_ranges();
    send_word(make_draw(32'sh8000_0000, 32'sh7fff_ffff));
    send_word(make_draw(32'sh8000_0000, 0));
    send_word(make_draw(-1, 32'sh7fff_ffff));
    send_word(make_draw(-1, 0));
    send_word(make_draw(32'sh7fff_fffe, 32'sh7fff_ffff));
  endtask

  task automatic test_reseed();
    send_word(make_reseed('0));
    send_word(make_draw(0, 1000));
    send_word(make_reseed(32'hffff_ffff));
    send_word(make_draw(32'sh8000_0000, 32'sh7fff_ffff));
    send_word(make_reseed(32'h8000_0000));
    send_word(make_draw(-100, 100));
    send_word(make_reseed('0));
    send_word(make_draw(-100, 100));
    send_word(make_reseed(32'd1));
    send_word(make_draw(0, 2));
  endtask

  task automatic test_random_traffic(input int unsigned n);
    int lo;
    int hi;
    int tmp;
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 19);
      lo = $urandom;
      hi = $urandom;
      if (pick < 3) begin
        send_word(make_reseed(($urandom_range(0, 9) == 0) ? '0 : $urandom));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            lo = int'($urandom_range(0, 2000000)) - 1000000;
            hi = lo + int'($urandom_range(1, 1000));
          end
          4, 5: begin
            if (lo > hi) begin
              tmp = lo;
              lo = hi;
              hi = tmp;
            end
          end
          6: hi = lo + (1 << $urandom_range(0, 31));
          7: begin
            lo = 32'sh8000_0000 + int'($urandom_range(0, 1 << 20));
            hi = 32'sh7fff_ffff - int'($urandom_range(0, 1 << 20));
          end
          8: hi = lo + int'($urandom_range(1, 3));
          default: hi = lo - int'($urandom_range(0, 5));
        endcase
        send_word(make_draw(lo, hi));
      end
    end
  endtask

  initial begin
    gen_model_state = GenResetValue;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_draw();
    test_empty_ranges();
    test_wide_ranges();
    test_reseed();
    test_random_traffic(800);
    idle_on = 1'b0;
    test_random_traffic(200);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0 && pending_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
